### rtl/typed_stack_compare_unit_assert.svh
// Assertion macros for the typed stack compare unit.
// Used by the top level; no other dependencies.
`ifndef TYPED_STACK_COMPARE_UNIT_ASSERT_SVH
`define TYPED_STACK_COMPARE_UNIT_ASSERT_SVH
// Check that an implication holds at every clock edge outside reset.
`define TSCU_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Check that an implication holds in the cycle after its antecedent.
`define TSCU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

### rtl/tscu_pkg.sv
// Package for the typed stack compare unit: codes and the compare function.
// No dependencies.
package tscu_pkg;
   typedef enum logic [2:0] {
      KIND_CONST = 3'd0, KIND_EQZ = 3'd1, KIND_EQ = 3'd2, KIND_NE = 3'd3,
      KIND_LT = 3'd4, KIND_GT = 3'd5, KIND_LE = 3'd6, KIND_GE = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      VT_I32 = 2'd0, VT_I64 = 2'd1, VT_F32 = 2'd2, VT_F64 = 2'd3
   } vtype_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_UNDERFLOW = 3'd1, ST_MISMATCH = 3'd2,
      ST_OVERFLOW = 3'd3, ST_ILLEGAL = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0, PH_READ = 2'd1, PH_EXEC = 2'd2, PH_OUT = 2'd3
   } phase_type;

   // Evaluate one test on two operands (a below b on the stack).
   function automatic logic run_test(input logic [2:0] kind, input logic [1:0] vt,
                                     input logic uns, input logic [63:0] a_in,
                                     input logic [63:0] b_in);
      logic        is32;
      logic [63:0] a, b, sb, ka, kb, em, mg;
      logic        eq, lt, nan_a, nan_b, r;
      is32 = (vt == VT_I32) || (vt == VT_F32);
      a = is32 ? {32'd0, a_in[31:0]} : a_in;
      b = is32 ? {32'd0, b_in[31:0]} : b_in;
      sb = is32 ? 64'h8000_0000 : 64'h8000_0000_0000_0000;
      em = is32 ? 64'h7F80_0000 : 64'h7FF0_0000_0000_0000;
      mg = sb - 64'd1;
      nan_a = ((a & em) == em) && ((a & mg & ~em) != 64'd0);
      nan_b = ((b & em) == em) && ((b & mg & ~em) != 64'd0);
      if (vt[1]) begin
         eq = (((a & mg) == 64'd0) && ((b & mg) == 64'd0)) || (a == b);
         ka = ((a & sb) != 64'd0) ? (~a & (is32 ? 64'hFFFF_FFFF : '1)) : (a | sb);
         kb = ((b & sb) != 64'd0) ? (~b & (is32 ? 64'hFFFF_FFFF : '1)) : (b | sb);
         lt = !eq && (ka < kb);
      end else begin
         ka = uns ? a : (a ^ sb);
         kb = uns ? b : (b ^ sb);
         eq = (a == b);
         lt = ka < kb;
      end
      case (kind)
         KIND_EQZ: r = (a == 64'd0);
         KIND_EQ:  r = eq;
         KIND_NE:  r = !eq;
         KIND_LT:  r = lt;
         KIND_GT:  r = !lt && !eq;
         KIND_LE:  r = lt || eq;
         default:  r = !lt;
      endcase
      if (vt[1] && kind != KIND_EQZ && (nan_a || nan_b)) begin
         r = (kind == KIND_NE);
      end
      return r;
   endfunction
endpackage

### rtl/typed_stack_compare_unit.sv
// Top level of the typed stack compare unit: sequencer, checks and result register.
// Depends on tscu_pkg, tscu_slot_mem and the assertion macro header.
//
// Usage: req_* carries one instruction (kind, operand type, unsigned flag,
// constant). rsp_* returns status, the test bit and the stack depth after it.
// One transaction is worked at a time: accept, read the top two slots from
// the memory (registered read), evaluate and write back, then show
// the result. A new transaction is taken only after the result is taken,
// so no new instruction is accepted before the last one is through.
// Reset clears the depth count and the sequencer; slot contents are left
// as they are and their data are only ever used below the depth count.
// When the receiver holds rsp_ready low, the result waits in its register
// and req_ready stays low.
`include "typed_stack_compare_unit_assert.svh"
module typed_stack_compare_unit
   import tscu_pkg::*;
#(
   parameter int STACK_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [1:0]  req_operand_type,
   input  logic        req_is_unsigned,
   input  logic [63:0] req_const_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic        rsp_result_bit,
   output logic [6:0]  rsp_stack_depth
);
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   phase_type      phase_ff, phase_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [2:0]     kind_ff;
   logic [1:0]     vt_ff;
   logic           uns_ff;
   logic [63:0]    cval_ff;
   logic [2:0]     status_ff, status_in;
   logic           bit_ff, bit_in;
   logic           wr_en;
   logic [AW-1:0]  wr_addr, addr_top, addr_base;
   logic [65:0]    wr_data, rd_top, rd_base;
   logic [CW-1:0]  need;
   logic           is32;

   // Address the top two slots from the current count
   always_comb begin
      need = (kind_ff == KIND_EQZ) ? CW'(1) : CW'(2);
      addr_top = AW'(count_ff - CW'(1));
      addr_base = AW'(count_ff - need);
   end

   tscu_slot_mem #(.DEPTH(STACK_DEPTH), .AW(AW)) u_mem (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr_a(addr_top), .rd_addr_b(addr_base),
      .rd_data_a(rd_top), .rd_data_b(rd_base)
   );

   // Check and evaluate in the execute phase
   always_comb begin
      is32 = (vt_ff == VT_I32) || (vt_ff == VT_F32);
      status_in = ST_OK;
      bit_in = 1'b0;
      count_in = count_ff;
      wr_en = 1'b0;
      wr_addr = addr_base;
      wr_data = {vt_ff, is32 ? {32'd0, cval_ff[31:0]} : cval_ff};
      if (kind_ff == KIND_CONST) begin
         if (count_ff >= CW'(STACK_DEPTH)) begin
            status_in = ST_OVERFLOW;
         end else begin
            wr_en = 1'b1;
            wr_addr = AW'(count_ff);
            count_in = count_ff + CW'(1);
         end
      end else if ((kind_ff == KIND_EQZ && vt_ff[1])
                   || (kind_ff >= KIND_LT && vt_ff[1] && uns_ff)) begin
         status_in = ST_ILLEGAL;
      end else if (count_ff < need) begin
         status_in = ST_UNDERFLOW;
      end else if (rd_top[65:64] != vt_ff || rd_base[65:64] != vt_ff) begin
         status_in = ST_MISMATCH;
      end else begin
         bit_in = run_test(kind_ff, vt_ff, uns_ff, rd_base[63:0], rd_top[63:0]);
         wr_en = 1'b1;
         wr_data = {VT_I32, 63'd0, bit_in};
         count_in = count_ff - need + CW'(1);
      end
      // Write back only once per transaction
      if (phase_ff != PH_EXEC) begin
         wr_en = 1'b0;
      end
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_IDLE: if (req_valid) phase_in = PH_READ;
         PH_READ: phase_in = PH_EXEC;
         PH_EXEC: phase_in = PH_OUT;
         PH_OUT:  if (rsp_ready) phase_in = PH_IDLE;
         default: phase_in = PH_IDLE;
      endcase
   end

   // Handshake outputs
   always_comb begin
      req_ready = (phase_ff == PH_IDLE);
      rsp_valid = (phase_ff == PH_OUT);
      rsp_status = status_ff;
      rsp_result_bit = bit_ff;
      rsp_stack_depth = 7'(count_ff);
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         if (phase_ff == PH_EXEC) begin
            count_ff <= count_in;
         end
      end
   end

   // Capture the transaction and its result
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         kind_ff <= req_kind;
         vt_ff <= req_operand_type;
         uns_ff <= req_is_unsigned;
         cval_ff <= req_const_value;
      end
      if (phase_ff == PH_EXEC) begin
         status_ff <= status_in;
         bit_ff <= bit_in;
      end
   end

   `TSCU_ASSERT_IMP(a_depth_bound, clock, reset, 1'b1, count_ff <= CW'(STACK_DEPTH))
   `TSCU_ASSERT_IMP(a_err_no_write, clock, reset, status_in != ST_OK, !wr_en)
   `TSCU_ASSERT_NEXT(a_count_only_exec, clock, reset, phase_ff != PH_EXEC,
                     count_ff == $past(count_ff))
   `TSCU_ASSERT_IMP(a_bit_ok, clock, reset, rsp_valid && rsp_status != ST_OK,
                    !rsp_result_bit)
endmodule

### rtl/tscu_slot_mem.sv
// Stack slot memory: 66-bit entries (type and value), one write and
// two registered read ports. Depends on nothing.
module tscu_slot_mem #(
   parameter int DEPTH = 64,
   parameter int AW = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [65:0]   wr_data,
   input  logic [AW-1:0] rd_addr_a,
   input  logic [AW-1:0] rd_addr_b,
   output logic [65:0]   rd_data_a,
   output logic [65:0]   rd_data_b
);
   logic [65:0] mem [DEPTH];

   // Write, then read both ports through output registers
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end
endmodule
